>>> rtl/core/darr_pkg.sv
// Shared types, constants and codes of the DNS A-record redirect responder.
package darr_pkg;

    // Request buffer size in bytes; bytes past it are dropped.
    localparam int BUFFER_BYTES = 512;
    // Request bytes held back until the header can be rewritten.
    localparam int HOLD_BYTES   = 17;
    localparam int HOLD_IDX_W   = $clog2(HOLD_BYTES);
    // Byte counter wide enough to hold the buffer size itself.
    localparam int IDX_W        = $clog2(BUFFER_BYTES + 1);
    // Most results that one request byte may cause.
    localparam int MAX_RESULTS  = 63;
    // Answer record length and the response length limit for appending one.
    localparam int ANSWER_BYTES = 16;
    localparam int ANS_SHIFT    = $clog2(ANSWER_BYTES);
    localparam int ANS_LIMIT    = BUFFER_BYTES - ANSWER_BYTES;
    // A-question counter saturates at this value.
    localparam int ANS_W        = 5;
    localparam int AQC_MAX      = 31;
    // Answer pairs that still fit in the result budget of one byte.
    localparam int RES_CAP_FLUSH = (MAX_RESULTS - 3) / 2;
    localparam int RES_CAP_OTHER = (MAX_RESULTS - 1) / 2;

    // Byte counts carried with each result word.
    localparam logic [3:0] CNT_WORD = 4'd8;
    localparam logic [3:0] CNT_BYTE = 4'd1;
    localparam logic [3:0] CNT_NONE = 4'd0;

    // Rewritten header flags: standard response, recursion available.
    localparam logic [7:0] FLAGS_HI = 8'h81;
    localparam logic [7:0] FLAGS_LO = 8'h80;

    // Answer record bytes: name pointer to offset 12, type A, class IN, TTL 60, length 4.
    localparam logic [7:0] PTR_HI   = 8'hC0;
    localparam logic [7:0] PTR_LO   = 8'h0C;
    localparam logic [7:0] TTL_LO   = 8'h3C;
    localparam logic [7:0] RDLEN_LO = 8'h04;
    localparam logic [63:0] ANS_WORD0 =
        {8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, PTR_LO, PTR_HI};
    localparam logic [31:0] ANS_WORD1_LO = {RDLEN_LO, 8'h00, TTL_LO, 8'h00};

    // Question type A.
    localparam logic [7:0] QTYPE_A_LO = 8'h01;

    // Request item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } req_t;

    // Response item.
    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        out_error;
        logic        out_last;
    } rsp_t;

    // Question section walker phases.
    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_LEN    = 8'b0000_0010,
        PH_SKIP   = 8'b0000_0100,
        PH_QT_HI  = 8'b0000_1000,
        PH_QT_LO  = 8'b0001_0000,
        PH_QC_HI  = 8'b0010_0000,
        PH_QC_LO  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    // Result segments that the output sequencer walks through.
    typedef enum logic [7:0] {
        SEG_FLUSH0 = 8'b0000_0001,
        SEG_FLUSH1 = 8'b0000_0010,
        SEG_FLUSH2 = 8'b0000_0100,
        SEG_ECHO   = 8'b0000_1000,
        SEG_ERROR  = 8'b0001_0000,
        SEG_EMPTY  = 8'b0010_0000,
        SEG_ANS0   = 8'b0100_0000,
        SEG_ANS1   = 8'b1000_0000
    } seg_t;

    // Work that one request byte hands to the output sequencer.
    typedef struct packed {
        seg_t             first_seg;
        logic [7:0]       echo_byte;
        logic [ANS_W-1:0] answers;
        logic             ends;
    } job_t;

    // Held header bytes.
    typedef logic [HOLD_BYTES-1:0][7:0] hold_t;

endpackage

>>> rtl/core/darr_parser.sv
// Request byte counter, header hold and question walker of the DNS responder.
module darr_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  darr_pkg::req_t req,
    output logic           job_valid,
    output darr_pkg::job_t job,
    output darr_pkg::hold_t hold
);
    import darr_pkg::*;

    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [15:0]       question_total_reg, question_total_next;
    logic [15:0]       questions_parsed_reg, questions_parsed_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        skip_left_reg, skip_left_next;
    logic [7:0]        qtype_hi_reg, qtype_hi_next;
    logic [ANS_W-1:0]  aqc_reg, aqc_next;
    hold_t             hold_reg;

    logic              taken;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  idx_after;
    logic              flush;
    logic              echo;
    logic              short_req;
    logic [IDX_W:0]    room;
    logic [IDX_W:0]    offset_cap;
    logic [IDX_W:0]    result_cap;
    logic [IDX_W:0]    aqc_wide;
    logic [IDX_W:0]    answer_cap;
    logic              more_questions;

    assign taken          = byte_index_reg < IDX_W'(BUFFER_BYTES);
    assign pos            = byte_index_reg;
    assign idx_after      = taken ? pos + IDX_W'(1) : pos;
    assign flush          = taken && (pos == IDX_W'(HOLD_BYTES - 1));
    assign echo           = taken && (pos >= IDX_W'(HOLD_BYTES));
    assign short_req      = idx_after < IDX_W'(HOLD_BYTES);
    assign more_questions = questions_parsed_reg < question_total_reg;

    // Walk the question section one byte at a time.
    always_comb
    begin
        byte_index_next       = byte_index_reg;
        question_total_next   = question_total_reg;
        questions_parsed_next = questions_parsed_reg;
        phase_next            = phase_reg;
        skip_left_next        = skip_left_reg;
        qtype_hi_next         = qtype_hi_reg;
        aqc_next              = aqc_reg;
        if (taken)
        begin
            byte_index_next = idx_after;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos == IDX_W'(4))
                        question_total_next = {req.in_byte, 8'h00};
                    if (pos == IDX_W'(5))
                        question_total_next = {question_total_reg[15:8], req.in_byte};
                    if (pos == IDX_W'(11))
                        phase_next = more_questions ? PH_LEN : PH_DONE;
                end
                PH_LEN:
                begin
                    if (req.in_byte == 8'h00)
                        phase_next = PH_QT_HI;
                    else
                    begin
                        skip_left_next = req.in_byte;
                        phase_next     = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_left_next = skip_left_reg - 8'd1;
                    if (skip_left_reg == 8'd1)
                        phase_next = PH_LEN;
                end
                PH_QT_HI:
                begin
                    qtype_hi_next = req.in_byte;
                    phase_next    = PH_QT_LO;
                end
                PH_QT_LO:
                begin
                    if (qtype_hi_reg == 8'h00 && req.in_byte == QTYPE_A_LO &&
                        aqc_reg < ANS_W'(AQC_MAX))
                        aqc_next = aqc_reg + ANS_W'(1);
                    questions_parsed_next = questions_parsed_reg + 16'd1;
                    phase_next            = PH_QC_HI;
                end
                PH_QC_HI:
                    phase_next = PH_QC_LO;
                PH_QC_LO:
                    phase_next = more_questions ? PH_LEN : PH_DONE;
                default:
                    phase_next = PH_DONE;
            endcase
        end
    end

    // Answers after the last byte: A questions, capped by room and budget.
    always_comb
    begin
        room = '0;
        if ({1'b0, idx_after} < (IDX_W + 1)'(ANS_LIMIT))
            room = (IDX_W + 1)'(ANS_LIMIT) - {1'b0, idx_after} +
                   (IDX_W + 1)'(ANSWER_BYTES - 1);
        offset_cap = room >> ANS_SHIFT;
        result_cap = flush ? (IDX_W + 1)'(RES_CAP_FLUSH) : (IDX_W + 1)'(RES_CAP_OTHER);
        aqc_wide   = (IDX_W + 1)'(aqc_next);
        answer_cap = aqc_wide;
        if (offset_cap < answer_cap)
            answer_cap = offset_cap;
        if (result_cap < answer_cap)
            answer_cap = result_cap;
    end

    // Describe the results of this byte for the output sequencer.
    always_comb
    begin
        job.echo_byte = req.in_byte;
        job.ends      = req.in_last;
        job.answers   = '0;
        if (req.in_last && !short_req)
            job.answers = answer_cap[ANS_W-1:0];
        if (req.in_last && short_req)
            job.first_seg = SEG_ERROR;
        else if (flush)
            job.first_seg = SEG_FLUSH0;
        else if (echo)
            job.first_seg = SEG_ECHO;
        else if (job.answers != '0)
            job.first_seg = SEG_ANS0;
        else
            job.first_seg = SEG_EMPTY;
        job_valid = flush || echo || req.in_last;
    end

    // Per-request state; the last byte returns it to its idle values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg       <= '0;
            question_total_reg   <= '0;
            questions_parsed_reg <= '0;
            phase_reg            <= PH_HEADER;
            skip_left_reg        <= '0;
            qtype_hi_reg         <= '0;
            aqc_reg              <= '0;
        end
        else if (accept)
        begin
            if (req.in_last)
            begin
                byte_index_reg       <= '0;
                question_total_reg   <= '0;
                questions_parsed_reg <= '0;
                phase_reg            <= PH_HEADER;
                skip_left_reg        <= '0;
                qtype_hi_reg         <= '0;
                aqc_reg              <= '0;
            end
            else
            begin
                byte_index_reg       <= byte_index_next;
                question_total_reg   <= question_total_next;
                questions_parsed_reg <= questions_parsed_next;
                phase_reg            <= phase_next;
                skip_left_reg        <= skip_left_next;
                qtype_hi_reg         <= qtype_hi_next;
                aqc_reg              <= aqc_next;
            end
        end
    end

    // Header bytes are kept until the rewritten header has been sent.
    always_ff @(posedge clk)
    begin
        if (accept && taken && pos < IDX_W'(HOLD_BYTES))
            hold_reg[pos[HOLD_IDX_W-1:0]] <= req.in_byte;
    end

    assign hold = hold_reg;

endmodule

>>> rtl/core/dns_a_record_redirect_responder.sv
// Top level of the DNS A-record redirect responder: parser, output sequencer, result register.
//
// Request bytes enter one per cycle while req_stall is low; each echoed byte leaves as a
// 1-byte item through the sequencer and result registers. The 17th byte releases the
// rewritten header as three items (8, 8 and 1 bytes), so the byte after it is stalled until
// they have gone out. The last byte yields its own items (none, one, or three when it is the
// 17th byte) plus 2 items per appended answer, up to 63 items, or one empty item when that
// adds up to none. The single result register takes one item per cycle from the output
// sequencer unless rsp_stall holds it; while the sequencer still has items of an earlier byte
// to send, req_stall is high. A request shorter than 17 bytes yields one error item.
// redirect_ip may be written through cfg_wr_en/cfg_wr_data only while no request is in flight.
module dns_a_record_redirect_responder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  darr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output darr_pkg::rsp_t rsp,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data
);
    import darr_pkg::*;

    logic             accept;
    logic             new_job_valid;
    job_t             new_job;
    hold_t            hold;

    logic [31:0]      redirect_ip_reg;
    logic             job_active_reg, job_active_next;
    seg_t             seg_reg, seg_next, seg_step;
    logic [7:0]       echo_reg, echo_next;
    logic [ANS_W-1:0] left_reg, left_next, left_step;
    logic             ends_reg, ends_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             out_load;
    logic             job_finish;
    logic [63:0]      cur_data;
    logic [3:0]       cur_count;
    logic             cur_error;
    logic             cur_final;

    assign out_load   = !rsp_valid_reg || !rsp_stall;
    assign job_finish = job_active_reg && out_load && cur_final;
    assign req_stall  = job_active_reg && !job_finish;
    assign accept     = req_valid && !req_stall;

    darr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .job_valid (new_job_valid),
        .job       (new_job),
        .hold      (hold)
    );

    // Result of the current segment and the segment that follows it.
    always_comb
    begin
        cur_data  = '0;
        cur_count = CNT_NONE;
        cur_error = 1'b0;
        cur_final = 1'b0;
        seg_step  = seg_reg;
        left_step = left_reg;
        unique case (seg_reg)
            SEG_FLUSH0:
            begin
                cur_data  = {hold[5], hold[4], hold[5], hold[4],
                             FLAGS_LO, FLAGS_HI, hold[1], hold[0]};
                cur_count = CNT_WORD;
                seg_step  = SEG_FLUSH1;
            end
            SEG_FLUSH1:
            begin
                cur_data  = {hold[15], hold[14], hold[13], hold[12], 32'h0};
                cur_count = CNT_WORD;
                seg_step  = SEG_FLUSH2;
            end
            SEG_FLUSH2:
            begin
                cur_data  = {56'h0, hold[16]};
                cur_count = CNT_BYTE;
                cur_final = (left_reg == '0);
                seg_step  = SEG_ANS0;
            end
            SEG_ECHO:
            begin
                cur_data  = {56'h0, echo_reg};
                cur_count = CNT_BYTE;
                cur_final = (left_reg == '0);
                seg_step  = SEG_ANS0;
            end
            SEG_ERROR:
            begin
                cur_error = 1'b1;
                cur_final = 1'b1;
            end
            SEG_EMPTY:
                cur_final = 1'b1;
            SEG_ANS0:
            begin
                cur_data  = ANS_WORD0;
                cur_count = CNT_WORD;
                seg_step  = SEG_ANS1;
            end
            SEG_ANS1:
            begin
                cur_data  = {redirect_ip_reg, ANS_WORD1_LO};
                cur_count = CNT_WORD;
                cur_final = (left_reg == ANS_W'(1));
                seg_step  = SEG_ANS0;
                left_step = left_reg - ANS_W'(1);
            end
            default:
                cur_final = 1'b1;
        endcase
    end

    // Sequencer: a new byte's work replaces the finished job in the same cycle.
    always_comb
    begin
        job_active_next = job_active_reg;
        seg_next        = seg_reg;
        echo_next       = echo_reg;
        left_next       = left_reg;
        ends_next       = ends_reg;
        if (accept && new_job_valid)
        begin
            job_active_next = 1'b1;
            seg_next        = new_job.first_seg;
            echo_next       = new_job.echo_byte;
            left_next       = new_job.answers;
            ends_next       = new_job.ends;
        end
        else if (job_finish)
            job_active_next = 1'b0;
        else if (job_active_reg && out_load)
        begin
            seg_next  = seg_step;
            left_next = left_step;
        end
    end

    // Result register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (out_load)
        begin
            rsp_valid_next     = job_active_reg;
            rsp_next.out_data  = cur_data;
            rsp_next.out_count = cur_count;
            rsp_next.out_error = cur_error;
            rsp_next.out_last  = ends_reg && cur_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            redirect_ip_reg <= '0;
            job_active_reg  <= 1'b0;
            seg_reg         <= SEG_EMPTY;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                redirect_ip_reg <= cfg_wr_data;
            job_active_reg <= job_active_next;
            seg_reg        <= seg_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg <= echo_next;
        left_reg <= left_next;
        ends_reg <= ends_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A second answer word always has a pair left to count down.
    a_ans1_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg && seg_reg == SEG_ANS1 |-> left_reg != '0)
        else $error("answer word sent with no answer pair left");

    // A blocked result register freezes the sequencer.
    a_seq_holds: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg && !out_load |=> job_active_reg && $stable(seg_reg))
        else $error("sequencer advanced while the result register was blocked");

    // An error item stands alone and carries no bytes.
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_error |-> rsp.out_last && rsp.out_count == CNT_NONE)
        else $error("error item without last mark or with bytes");

    // Input is taken only when the sequencer has room for its work.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept && new_job_valid |=> job_active_reg)
        else $error("accepted byte left no work in the sequencer");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the DNS A-record redirect responder.
module tb_top;
    import darr_pkg::*;

    // Clock period is 4 time units; the run is cut off well beyond the slowest correct run.
    localparam int WATCHDOG_TIME = 2_000_000;
    // Cycles to let pass after the last expected item: the last byte may emit 63 items.
    localparam int SETTLE_CYCLES = 70;
    localparam int DIRECTED_ROWS = 20;

    // Byte counts carried with response items.
    localparam logic [3:0] WORD_BYTES = 4'd8;
    localparam logic [3:0] ONE_BYTE   = 4'd1;
    localparam logic [3:0] NO_BYTES   = 4'd0;

    // Rewritten header flags, in the order they leave the block.
    localparam logic [7:0] FLAG_BYTE0 = 8'h81;
    localparam logic [7:0] FLAG_BYTE1 = 8'h80;
    localparam logic [7:0] TYPE_A_LOW = 8'h01;
    localparam logic [4:0] A_COUNT_MAX = 5'd31;

    // Fixed part of each answer: name pointer, type A, class IN, TTL 60, length 4.
    localparam logic [63:0] ANSWER_NAME_WORD = 64'h0000_0100_0100_0CC0;
    localparam logic [31:0] ANSWER_TTL_LEN   = 32'h0400_3C00;

    // A request too short to answer ends in this single item.
    localparam rsp_t ERROR_WORD = {64'h0, NO_BYTES, 1'b1, 1'b1};
    localparam rsp_t NO_WORD    = '0;

    // One row of the directed table: the request item, and a typed-in response where obvious.
    typedef struct packed {
        req_t item;
        logic typed;
        rsp_t want;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    req_t     req;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    rsp_t     rsp;
    logic     cfg_wr_en;
    logic [31:0] cfg_wr_data;

    // Predictor state: a private copy of the request walker and the answer address.
    logic [31:0]      answer_ip;
    logic [7:0]       held [HOLD_BYTES];
    logic [IDX_W-1:0] rx_count;
    logic [15:0]      qd_total;
    logic [15:0]      qd_walked;
    phase_t           walk_phase;
    logic [7:0]       skip_left;
    logic [7:0]       qtype_hi;
    logic [4:0]       a_count;

    rsp_t        byte_words [$];
    rsp_t        pending_words [$];
    logic [7:0]  msg_bytes [$];
    dir_row_t    directed_rows [DIRECTED_ROWS];

    bit          stall_on = 1'b0;
    int          stall_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_checked = 0;
    int unsigned errors_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned requests_sent = 0;

    dns_a_record_redirect_responder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    // Return all per-request state to its idle value.
    function automatic void restart_request();
        foreach (held[i])
        begin
            held[i] = 8'h00;
        end
        rx_count   = '0;
        qd_total   = 16'h0;
        qd_walked  = 16'h0;
        walk_phase = PH_HEADER;
        skip_left  = 8'h0;
        qtype_hi   = 8'h0;
        a_count    = 5'd0;
    endfunction

    function automatic rsp_t make_word(logic [63:0] data, logic [3:0] count, logic err);
        rsp_t w;
        w.out_data  = data;
        w.out_count = count;
        w.out_error = err;
        w.out_last  = 1'b0;
        return w;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Walk the question section one byte at a time and count questions of type A.
    function automatic void walk_question_byte(int unsigned pos, logic [7:0] b);
        case (walk_phase)
            PH_HEADER:
            begin
                if (pos == 4) qd_total[15:8] = b;
                if (pos == 5) qd_total[7:0] = b;
                if (pos == 11) walk_phase = (qd_walked < qd_total) ? PH_LEN : PH_DONE;
            end
            PH_LEN:
            begin
                if (b == 8'h00)
                begin
                    walk_phase = PH_QT_HI;
                end
                else
                begin
                    skip_left  = b;
                    walk_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'h0) walk_phase = PH_LEN;
            end
            PH_QT_HI:
            begin
                qtype_hi   = b;
                walk_phase = PH_QT_LO;
            end
            PH_QT_LO:
            begin
                if (qtype_hi == 8'h00 && b == TYPE_A_LOW && a_count < A_COUNT_MAX)
                    a_count = a_count + 5'd1;
                qd_walked  = qd_walked + 16'd1;
                walk_phase = PH_QC_HI;
            end
            PH_QC_HI:
            begin
                walk_phase = PH_QC_LO;
            end
            PH_QC_LO:
            begin
                walk_phase = (qd_walked < qd_total) ? PH_LEN : PH_DONE;
            end
            default:
            begin
                walk_phase = PH_DONE;
            end
        endcase
    endfunction

    // Work out the response items that one accepted request byte causes.
    function automatic void respond_to_byte(req_t item);
        int unsigned pos;
        int unsigned reply_len;
        int unsigned answers;
        rsp_t        w;
        byte_words.delete();
        if (rx_count < BUFFER_BYTES)
        begin
            pos = 32'(rx_count);
            walk_question_byte(pos, item.in_byte);
            if (pos < HOLD_BYTES) held[pos[HOLD_IDX_W-1:0]] = item.in_byte;
            rx_count = IDX_W'(pos + 1);
            if (rx_count == HOLD_BYTES)
            begin
                // Header release: flags rewritten, question count copied into the answer count, other counts zeroed.
                byte_words.push_back(make_word({held[5], held[4], held[5], held[4],
                    FLAG_BYTE1, FLAG_BYTE0, held[1], held[0]}, WORD_BYTES, 1'b0));
                byte_words.push_back(make_word({held[15], held[14], held[13], held[12],
                    32'h0}, WORD_BYTES, 1'b0));
                byte_words.push_back(make_word({56'h0, held[16]}, ONE_BYTE, 1'b0));
            end
            else if (rx_count > HOLD_BYTES)
            begin
                byte_words.push_back(make_word({56'h0, item.in_byte}, ONE_BYTE, 1'b0));
            end
        end
        if (item.in_last)
        begin
            if (rx_count < HOLD_BYTES)
            begin
                byte_words.delete();
                byte_words.push_back(make_word(64'h0, NO_BYTES, 1'b1));
            end
            else
            begin
                // Append answers while the response stays in the buffer and the item budget.
                reply_len = 32'(rx_count);
                answers   = 0;
                while (answers < a_count && reply_len < BUFFER_BYTES - 16 &&
                       byte_words.size() + 2 <= MAX_RESULTS)
                begin
                    byte_words.push_back(make_word(ANSWER_NAME_WORD, WORD_BYTES, 1'b0));
                    byte_words.push_back(make_word({answer_ip, ANSWER_TTL_LEN},
                        WORD_BYTES, 1'b0));
                    reply_len += 16;
                    answers++;
                end
                if (byte_words.size() == 0)
                    byte_words.push_back(make_word(64'h0, NO_BYTES, 1'b0));
            end
            w = byte_words.pop_back();
            w.out_last = 1'b1;
            byte_words.push_back(w);
            restart_request();
        end
    endfunction

    // Twelve header bytes with the given question count and random other fields.
    function automatic void push_header(logic [15:0] qd);
        repeat (4) msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(qd[15:8]);
        msg_bytes.push_back(qd[7:0]);
        repeat (6) msg_bytes.push_back(rand_byte());
    endfunction

    // Present one item, optionally after an idle burst, and predict once it is taken.
    task automatic send_item(input req_t item, input bit gaps, input bit typed,
                             input rsp_t want);
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        bytes_sent++;
        respond_to_byte(item);
        if (typed)
            pending_words.push_back(want);
        else
            foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
    endtask

    task automatic send_message(input bit gaps);
        req_t item;
        foreach (msg_bytes[i])
        begin
            item.in_byte = msg_bytes[i];
            item.in_last = (i == msg_bytes.size() - 1);
            send_item(item, gaps, 1'b0, NO_WORD);
        end
        requests_sent++;
    endtask

    // Stop sending and wait until every expected item has come, then let the block go idle.
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ip(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        answer_ip = value;
    endtask

    // Random requests: mostly well-formed question sections, some broken, some noise.
    task automatic run_random(input int unsigned goal, input bit with_idling);
        int unsigned pick;
        int unsigned len;
        int unsigned qcount;
        int unsigned keep;
        bit          gaps;
        while (bytes_sent < goal)
        begin
            msg_bytes.delete();
            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                len = $urandom_range(1, HOLD_BYTES - 1);
                repeat (len) msg_bytes.push_back(rand_byte());
            end
            else if (pick < 6)
            begin
                len = $urandom_range(HOLD_BYTES, 48);
                repeat (len) msg_bytes.push_back(rand_byte());
            end
            else
            begin
                qcount = $urandom_range(0, 4);
                push_header(16'(qcount));
                if ($urandom_range(0, 7) == 0)
                begin
                    msg_bytes[4] = rand_byte();
                    msg_bytes[5] = rand_byte();
                end
                repeat (qcount)
                begin
                    repeat ($urandom_range(0, 2))
                    begin
                        len = $urandom_range(1, 6);
                        msg_bytes.push_back(8'(len));
                        repeat (len) msg_bytes.push_back(rand_byte());
                    end
                    msg_bytes.push_back(8'h00);
                    case ($urandom_range(0, 5))
                        3:
                        begin
                            msg_bytes.push_back(8'h00);
                            msg_bytes.push_back(rand_byte());
                        end
                        4:
                        begin
                            msg_bytes.push_back(rand_byte());
                            msg_bytes.push_back(TYPE_A_LOW);
                        end
                        5:
                        begin
                            msg_bytes.push_back(rand_byte());
                            msg_bytes.push_back(rand_byte());
                        end
                        default:
                        begin
                            msg_bytes.push_back(8'h00);
                            msg_bytes.push_back(TYPE_A_LOW);
                        end
                    endcase
                    msg_bytes.push_back(rand_byte());
                    msg_bytes.push_back(rand_byte());
                end
                // Cut the request short, or leave extra bytes after the questions.
                if ($urandom_range(0, 5) == 0)
                begin
                    keep = $urandom_range(1, msg_bytes.size());
                    while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 8)) msg_bytes.push_back(rand_byte());
                end
            end
            gaps     = with_idling && ($urandom_range(0, 3) != 0);
            stall_on = with_idling && ($urandom_range(0, 3) != 0);
            send_message(gaps);
        end
    endtask

    // Response side stalls in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Compare each accepted response item with the oldest expectation.
    always @(posedge clk)
    begin : check_words
        rsp_t want;
        if (rst_n === 1'b1 && rsp_valid && !rsp_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got data %h count %0d %s",
                         $time, rsp.out_data, rsp.out_count,
                         $sformatf("err %b last %b", rsp.out_error, rsp.out_last));
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (rsp.out_data !== want.out_data)
                    report_field("out_data", want.out_data, rsp.out_data);
                if (rsp.out_count !== want.out_count)
                    report_field("out_count", 64'(want.out_count), 64'(rsp.out_count));
                if (rsp.out_error !== want.out_error)
                    report_field("out_error", 64'(want.out_error), 64'(rsp.out_error));
                if (rsp.out_last !== want.out_last)
                    report_field("out_last", 64'(want.out_last), 64'(rsp.out_last));
                words_checked++;
                if (want.out_error) errors_seen++;
            end
        end
    end

    initial
    begin
        #(WATCHDOG_TIME);
        $display("%0t: timeout with %0d items still expected", $time, pending_words.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int unsigned a_questions;
        int unsigned start;

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req         <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 32'h0;
        answer_ip = 32'h0;
        restart_request();

        // Columns: request byte, last mark, typed-in flag, typed-in response.
        directed_rows = '{
            {8'hA5, 1'b1, 1'b1, ERROR_WORD},   // one-byte request after reset
            {8'h00, 1'b1, 1'b1, ERROR_WORD},
            {8'hFF, 1'b1, 1'b1, ERROR_WORD},
            // Smallest answerable request: one A question with the root name, 17 bytes.
            {8'hFF, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h01, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h01, 1'b0, 1'b0, NO_WORD},
            {8'hFF, 1'b0, 1'b0, NO_WORD},
            {8'hFF, 1'b0, 1'b0, NO_WORD},
            {8'h12, 1'b0, 1'b0, NO_WORD},
            {8'h34, 1'b0, 1'b0, NO_WORD},
            {8'hAB, 1'b0, 1'b0, NO_WORD},
            {8'hCD, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h01, 1'b0, 1'b0, NO_WORD},
            {8'h00, 1'b0, 1'b0, NO_WORD},
            {8'h01, 1'b1, 1'b0, NO_WORD}   // last byte is the 17th: header plus answer
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_ip(32'hFFFF_FFFF);
        stall_on = 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i].item, 1'b1, directed_rows[i].typed,
                      directed_rows[i].want);
        requests_sent += 4;
        settle();

        write_ip($urandom);
        run_random(bytes_sent + 35, 1'b1);
        settle();

        // Long request: 33 A questions saturate the counter and the buffer caps the answers.
        write_ip(32'h0);
        msg_bytes.delete();
        a_questions = 33;
        push_header(16'(a_questions));
        repeat (a_questions)
        begin
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(TYPE_A_LOW);
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(8'h01);
        end
        stall_on = 1'b1;
        send_message(1'b1);
        settle();

        write_ip($urandom);
        start = bytes_sent;
        run_random(start + 15, 1'b1);
        // Closing stretch at full rate on both sides.
        stall_on = 1'b0;
        run_random(start + 30, 1'b0);
        settle();

        $display("Sent %0d requests in %0d bytes; checked %0d response items, %0d of them errors.",
                 requests_sent, bytes_sent, words_checked, errors_seen);
        $display("Covered short, noisy, truncated and long requests over 4 addresses.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/darr_pkg.sv
rtl/core/darr_parser.sv
rtl/core/dns_a_record_redirect_responder.sv
dv/tb_top.sv
